[rtl/ssir_pkg.sv]
`timescale 1ns / 1ps

package ssir_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int COUNT_W     = 5;
  localparam int STATUS_W    = 3;
  localparam int OUT_BITS    = STATUS_W + COUNT_W + 1;
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_W        = ((VALUE_WIDTH + 7) / 8) * 8;

  typedef logic [VALUE_WIDTH-1:0] key_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_WAS_EMPTY = 3'd5
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  // Broadcast from the control to every cell of the chain.
  typedef struct packed {
    logic do_ins;
    logic do_rem;
    key_t key;
  } ssir_cmd_t;

  // Sign bit inverted so that unsigned order equals signed order.
  function automatic key_t order_key(input logic [VALUE_WIDTH-1:0] raw);
    order_key = raw ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  endfunction

endpackage

[rtl/ssir_cell.sv]
`timescale 1ns / 1ps

module ssir_cell import ssir_pkg::*; (
  input  logic      clk,
  input  ssir_cmd_t cmd,
  input  logic      in_range,
  input  logic      left_lt,
  input  key_t      left_key,
  input  key_t      right_key,
  output key_t      key,
  output logic      lt,
  output logic      eq
);

  assign lt = in_range && (key < cmd.key);
  assign eq = in_range && (key == cmd.key);

  // Cells below the insertion point keep their entry; the first cell at or
  // above it takes the new key and the rest move one place up. A removal
  // pulls every entry from the match upwards one place down.
  always_ff @(posedge clk) begin
    if (cmd.do_ins && !lt) begin
      key <= left_lt ? cmd.key : left_key;
    end else if (cmd.do_rem && !lt) begin
      key <= right_key;
    end
  end

endmodule

[rtl/sorted_set_insert_remove_core.sv]
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Payload
// s       | in        | s_tvalid/s_tready  | s_tuser: req_type; s_tdata: value
// m       | out       | m_tvalid/m_tready  | m_tdata: status, count, is_empty
//
// Each request is first registered; then every cell compares its entry
// with the key and, on an insert or a removal, the chain shifts by one place.
// The compare across the cell chain and the count decide the status, which
// is registered. A new request is taken once the previous one has executed.
// A result waiting on m holds the next request in its register until taken.
// Reset clears the count and handshake state; stored entries need no reset.

module sorted_set_insert_remove_core import ssir_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [0:0]       s_tuser,   // [0] req_type
  input  logic [IN_W-1:0]  s_tdata,   // [31:0] value
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // [2:0] status, [7:3] count, [8] is_empty
);

  logic             pend;
  req_t             req_kind;
  key_t             req_key;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  status_t          status_next;
  status_t          status_q;
  logic [CNT_W-1:0] count_q;
  logic             exec;
  logic             found;
  ssir_cmd_t        cmd;

  key_t             cell_key [DEPTH];
  logic [DEPTH-1:0] cell_lt;
  logic [DEPTH-1:0] cell_eq;

  assign s_tready = !pend;
  assign exec     = pend && (!m_tvalid || m_tready);
  assign found    = |cell_eq;

  always_comb begin
    cmd.key     = req_key;
    cmd.do_ins  = 1'b0;
    cmd.do_rem  = 1'b0;
    fill_next   = fill;
    status_next = ST_INSERTED;
    if (req_kind == REQ_REMOVE) begin
      if (fill == '0) begin
        status_next = ST_WAS_EMPTY;
      end else if (!found) begin
        status_next = ST_NOT_FOUND;
      end else begin
        status_next = ST_REMOVED;
        cmd.do_rem  = exec;
        fill_next   = fill - 1'b1;
      end
    end else begin
      if (found) begin
        status_next = ST_DUPLICATE;
      end else if (fill == CNT_W'(DEPTH)) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
        cmd.do_ins  = exec;
        fill_next   = fill + 1'b1;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic in_range;
    logic left_lt;
    key_t left_key;
    key_t right_key;

    assign in_range = (CNT_W'(i) < fill);
    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_key = req_key;
    end else begin : g_mid
      assign left_lt  = cell_lt[i-1];
      assign left_key = cell_key[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_key = req_key;
    end else begin : g_body
      assign right_key = cell_key[i+1];
    end

    ssir_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .in_range  (in_range),
      .left_lt   (left_lt),
      .left_key  (left_key),
      .right_key (right_key),
      .key       (cell_key[i]),
      .lt        (cell_lt[i]),
      .eq        (cell_eq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
      fill     <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        pend <= 1'b1;
      end else if (exec) begin
        pend <= 1'b0;
      end
      if (exec) begin
        m_tvalid <= 1'b1;
        fill     <= fill_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_kind <= req_t'(s_tuser[0]);
      req_key  <= order_key(s_tdata[VALUE_WIDTH-1:0]);
    end
    if (exec) begin
      status_q <= status_next;
      count_q  <= fill_next;
    end
  end

  assign m_tdata = {{(OUT_W-OUT_BITS){1'b0}}, (count_q == '0),
                    COUNT_W'(count_q), status_q};

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (exec && cmd.do_ins) |=> (fill == $past(fill) + 1'b1))
    else $error("insert did not grow the count");

  a_ordered: assert property (@(posedge clk) disable iff (rst)
    (fill >= CNT_W'(2)) |-> (cell_key[0] < cell_key[1]))
    else $error("first two entries out of order");

  a_no_double_hit: assert property (@(posedge clk) disable iff (rst)
    pend |-> $onehot0(cell_eq))
    else $error("key matched more than one cell");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import ssir_pkg::*;

  localparam int RANDOM_ITEMS = 827;
  localparam int IDLE_LIMIT   = 5000;
  localparam int POOL_SIZE    = 24;
  localparam int N_DIRECTED   = 23;

  typedef struct {
    status_t    st;
    logic [4:0] cnt;
    logic       empty;
  } set_result_t;

  typedef struct {
    req_t        kind;
    logic [31:0] value;
    bit          typed;
    set_result_t want;
  } request_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [0:0]       s_tuser = '0;   // [0] req_type
  logic [IN_W-1:0]  s_tdata = '0;   // [31:0] value
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // [2:0] status, [7:3] count, [8] is_empty

  sorted_set_insert_remove_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Our own copy of the table, signed order, only entries below stored_cnt valid.
  logic signed [VALUE_WIDTH-1:0] sorted_copy [DEPTH];
  int                            stored_cnt = 0;

  set_result_t  pending_results [$];
  request_row_t sent_rows [$];
  request_row_t directed [N_DIRECTED];
  logic [31:0]  value_pool [POOL_SIZE];
  int           mismatches = 0;
  int           idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic set_result_t set_apply(input req_t kind,
                                            input logic signed [VALUE_WIDTH-1:0] v);
    set_result_t r;
    int          pos;
    pos = 0;
    while (pos < stored_cnt && sorted_copy[pos] < v) pos++;
    if (kind == REQ_INSERT) begin
      if (pos < stored_cnt && sorted_copy[pos] == v) begin
        r.st = ST_DUPLICATE;
      end else if (stored_cnt >= DEPTH) begin
        r.st = ST_FULL;
      end else begin
        for (int i = stored_cnt; i > pos; i--) sorted_copy[i] = sorted_copy[i-1];
        sorted_copy[pos] = v;
        stored_cnt++;
        r.st = ST_INSERTED;
      end
    end else begin
      if (stored_cnt == 0) begin
        r.st = ST_WAS_EMPTY;
      end else if (pos >= stored_cnt || sorted_copy[pos] != v) begin
        r.st = ST_NOT_FOUND;
      end else begin
        for (int i = pos; i < stored_cnt - 1; i++) sorted_copy[i] = sorted_copy[i+1];
        stored_cnt--;
        r.st = ST_REMOVED;
      end
    end
    r.cnt   = stored_cnt[4:0];
    r.empty = (stored_cnt == 0);
    return r;
  endfunction

  // Requests are predicted as they are taken; results are checked as they leave.
  always @(posedge clk) begin
    set_result_t  want;
    request_row_t row;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d count %0d empty %0d",
                     m_tdata[2:0], m_tdata[7:3], m_tdata[8]);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[2:0] !== want.st || m_tdata[7:3] !== want.cnt ||
              m_tdata[8] !== want.empty) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d count %0d empty %0d, got %0d %0d %0d",
                       want.st, want.cnt, want.empty,
                       m_tdata[2:0], m_tdata[7:3], m_tdata[8]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        row  = sent_rows.pop_front();
        want = set_apply(req_t'(s_tuser[0]), s_tdata[VALUE_WIDTH-1:0]);
        pending_results.push_back(row.typed ? row.want : want);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // The receiver alternates between always ready, coin-flip and long stalls.
  int seg_left = 0;
  int seg_mode = 0;
  always @(negedge clk) begin
    if (seg_left == 0) begin
      seg_mode = $urandom_range(0, 2);
      seg_left = $urandom_range(20, 80);
    end else begin
      seg_left--;
    end
    case (seg_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  task automatic send_request(input request_row_t row);
    sent_rows.push_back(row);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= row.kind;
    s_tdata  <= row.value;
    do @(posedge clk); while (!s_tready);
  endtask

  int burst_left = 0;

  task automatic pace_and_send(input request_row_t row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    send_request(row);
  endtask

  function automatic request_row_t checked_row(input req_t kind, input logic [31:0] v,
                                               input status_t st, input int cnt);
    request_row_t r;
    r.kind      = kind;
    r.value     = v;
    r.typed     = 1'b1;
    r.want.st    = st;
    r.want.cnt   = cnt[4:0];
    r.want.empty = (cnt == 0);
    return r;
  endfunction

  function automatic request_row_t open_row(input req_t kind, input logic [31:0] v);
    request_row_t r;
    r.kind      = kind;
    r.value     = v;
    r.typed     = 1'b0;
    r.want.st    = ST_INSERTED;
    r.want.cnt   = '0;
    r.want.empty = 1'b0;
    return r;
  endfunction

  initial begin
    logic [31:0] fill_vals [14];
    request_row_t row;
    int phase_left;
    int insert_bias;

    fill_vals = '{32'hFFFF_FFFF, 32'h0, 32'h1, -32'sd100, 32'd100, 32'd2, -32'sd2,
                  32'd3, -32'sd3, 32'h4000_0000, 32'hC000_0000, 32'd7, -32'sd7, 32'd1000};

    // Empty table, both extremes, a duplicate and a miss, then filled to the
    // brim so that a full table sees a duplicate and a fresh value; last, both extremes are removed.
    directed[0] = checked_row(REQ_REMOVE, 32'h0, ST_WAS_EMPTY, 0);
    directed[1] = checked_row(REQ_INSERT, 32'h7FFF_FFFF, ST_INSERTED, 1);
    directed[2] = checked_row(REQ_INSERT, 32'h8000_0000, ST_INSERTED, 2);
    directed[3] = checked_row(REQ_INSERT, 32'h7FFF_FFFF, ST_DUPLICATE, 2);
    directed[4] = checked_row(REQ_REMOVE, 32'd5, ST_NOT_FOUND, 2);
    for (int i = 0; i < 14; i++) directed[5 + i] = open_row(REQ_INSERT, fill_vals[i]);
    directed[19] = checked_row(REQ_INSERT, 32'h0, ST_DUPLICATE, 16);
    directed[20] = checked_row(REQ_INSERT, 32'd5, ST_FULL, 16);
    directed[21] = checked_row(REQ_REMOVE, 32'h8000_0000, ST_REMOVED, 15);
    directed[22] = checked_row(REQ_REMOVE, 32'h7FFF_FFFF, ST_REMOVED, 14);

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) pace_and_send(directed[i]);

    // A pool larger than the table lets phases of inserts fill it and phases
    // of removes drain it, so full and empty come round again and again.
    phase_left  = 0;
    insert_bias = 80;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (phase_left == 0) begin
        phase_left  = $urandom_range(30, 60);
        insert_bias = (insert_bias > 50) ? 20 : 80;
      end
      phase_left--;
      row = open_row(($urandom_range(0, 99) < insert_bias) ? REQ_INSERT : REQ_REMOVE,
                     ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                : $urandom);
      pace_and_send(row);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
